/* design/sgsc_pkg.sv */
// shared widths, codes and types for the staggered grid sample coordinate block
package sgsc_pkg;

  // field widths
  localparam int unsigned IN_W       = 6;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned REG_GAP_W  = 8;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned GAP_W      = SIZE_W + FRAC_W;
  localparam int unsigned QUART_W    = 3;
  localparam int unsigned FACT_W     = IN_W + 3;
  localparam int unsigned PROD_W     = GAP_W + FACT_W;
  localparam int unsigned ROUND_SH   = FRAC_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  // output grid size defaults
  localparam int unsigned OUT_ROWS_DEF = 64;
  localparam int unsigned OUT_COLS_DEF = 64;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_AUTO_GAP = 3'd0,
    CFG_COLUMN_GAP   = 3'd1,
    CFG_ROW_GAP      = 3'd2,
    CFG_STAGGER_MODE = 3'd3,
    CFG_SOURCE_ROWS  = 3'd4,
    CFG_SOURCE_COLS  = 3'd5
  } cfg_idx_e;

  // stagger modes
  localparam logic [MODE_W-1:0] MODE_H_HALF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_H_QUARTER = 3'd1;
  localparam logic [MODE_W-1:0] MODE_H_3QUART  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_V_QUARTER = 3'd3;

  // phase in quarters of a gap
  localparam logic [QUART_W-1:0] Q_ONE   = 3'd1;
  localparam logic [QUART_W-1:0] Q_HALF  = 3'd2;
  localparam logic [QUART_W-1:0] Q_THREE = 3'd3;
  localparam logic [QUART_W-1:0] Q_FULL  = 3'd4;

  // reset values of the registers
  localparam logic                  RST_USE_AUTO_GAP = 1'b0;
  localparam logic [REG_GAP_W-1:0]  RST_COLUMN_GAP   = 8'd4;
  localparam logic [REG_GAP_W-1:0]  RST_ROW_GAP      = 8'd4;
  localparam logic [MODE_W-1:0]     RST_STAGGER_MODE = 3'd4;
  localparam logic [SIZE_W-1:0]     RST_SOURCE_ROWS  = 13'd280;
  localparam logic [SIZE_W-1:0]     RST_SOURCE_COLS  = 13'd1000;

  // register file contents
  typedef struct packed {
    logic                 use_auto_gap;
    logic [REG_GAP_W-1:0] column_gap;
    logic [REG_GAP_W-1:0] row_gap;
    logic [MODE_W-1:0]    stagger_mode;
    logic [SIZE_W-1:0]    source_rows;
    logic [SIZE_W-1:0]    source_cols;
  } cfg_t;

  // per-axis derived settings
  typedef struct packed {
    logic [GAP_W-1:0]   gap;
    logic [COORD_W-1:0] lim;
  } axis_cfg_t;

  // pipeline stage enables
  typedef struct packed {
    logic prod_en;
    logic out_en;
  } stage_ctrl_t;

endpackage

/* design/sgsc_in_if.sv */
// input channel carrying one output grid position per item
interface sgsc_in_if import sgsc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] out_row;
  logic [IN_W-1:0] out_col;

  modport source (output valid, output out_row, output out_col, input ready);
  modport sink   (input valid, input out_row, input out_col, output ready);
endinterface

/* design/sgsc_out_if.sv */
// output channel carrying one source pixel coordinate per item
interface sgsc_out_if import sgsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] sample_row;
  logic [COORD_W-1:0] sample_col;

  modport source (output valid, output sample_row, output sample_col, input ready);
  modport sink   (input valid, input sample_row, input sample_col, output ready);
endinterface

/* design/sgsc_cfg_regs.sv */
// configuration register file with plain write port
module sgsc_cfg_regs import sgsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_auto_gap <= RST_USE_AUTO_GAP;
      cfg_q.column_gap   <= RST_COLUMN_GAP;
      cfg_q.row_gap      <= RST_ROW_GAP;
      cfg_q.stagger_mode <= RST_STAGGER_MODE;
      cfg_q.source_rows  <= RST_SOURCE_ROWS;
      cfg_q.source_cols  <= RST_SOURCE_COLS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_USE_AUTO_GAP: cfg_q.use_auto_gap <= cfg_wdata_i[0];
        CFG_COLUMN_GAP:   cfg_q.column_gap   <= cfg_wdata_i[REG_GAP_W-1:0];
        CFG_ROW_GAP:      cfg_q.row_gap      <= cfg_wdata_i[REG_GAP_W-1:0];
        CFG_STAGGER_MODE: cfg_q.stagger_mode <= cfg_wdata_i[MODE_W-1:0];
        CFG_SOURCE_ROWS:  cfg_q.source_rows  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SOURCE_COLS:  cfg_q.source_cols  <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/sgsc_gap_calc.sv */
// per-axis gap and clamp limit, registered from the configuration
module sgsc_gap_calc import sgsc_pkg::*; #(
  parameter int unsigned OUT_SIZE = OUT_COLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 use_auto_gap_i,
  input  logic [REG_GAP_W-1:0] reg_gap_i,
  input  logic [SIZE_W-1:0]    size_i,
  output axis_cfg_t            axis_o
);

  // floor(x / OUT_SIZE) for x below 2^GAP_W as a multiply by a rounded-up reciprocal
  localparam int unsigned    LOG_D     = $clog2(OUT_SIZE);
  localparam int unsigned    RECIP_SH  = GAP_W + LOG_D;
  localparam longint unsigned RECIP    =
    ((64'd1 << RECIP_SH) + longint'(OUT_SIZE) - 64'd1) / longint'(OUT_SIZE);
  localparam logic [COORD_W-1:0] MAX_LIM = {COORD_W{1'b1}};

  logic [GAP_W-1:0]   num;
  logic [63:0]        prod;
  logic [GAP_W-1:0]   derived_gap;
  logic [SIZE_W-1:0]  size_m1;
  axis_cfg_t          axis_d;
  axis_cfg_t          axis_q;

  // derived gap: (size << 8) / OUT_SIZE
  assign num         = {size_i, {FRAC_W{1'b0}}};
  assign prod        = 64'(num) * RECIP;
  assign derived_gap = GAP_W'(prod >> RECIP_SH);

  // gap select and clamp limit, zero size clamps to zero
  assign size_m1 = size_i - SIZE_W'(1);
  always_comb begin
    axis_d.gap = use_auto_gap_i ? derived_gap
                                : GAP_W'({reg_gap_i, {FRAC_W{1'b0}}});
    if (size_i == '0) begin
      axis_d.lim = '0;
    end else if (size_m1 > SIZE_W'(MAX_LIM)) begin
      axis_d.lim = MAX_LIM;
    end else begin
      axis_d.lim = size_m1[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d;
  end

  assign axis_o = axis_q;

endmodule

/* design/sgsc_place.sv */
// one axis: gap times position factor, then round half up and clamp
module sgsc_place import sgsc_pkg::*; (
  input  logic               clk_i,
  input  stage_ctrl_t        ctrl_i,
  input  logic [FACT_W-1:0]  factor_i,
  input  axis_cfg_t          axis_i,
  output logic [COORD_W-1:0] coord_o
);

  localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (ROUND_SH - 1);

  logic [PROD_W-1:0]          prod_d;
  logic [PROD_W-1:0]          prod_q;
  logic [PROD_W:0]            rounded;
  logic [PROD_W-ROUND_SH:0]   whole;
  logic [COORD_W-1:0]         coord_d;
  logic [COORD_W-1:0]         coord_q;

  // position in quarter-gap units, exact
  assign prod_d = PROD_W'(axis_i.gap) * PROD_W'(factor_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      prod_q <= prod_d;
    end
  end

  // round half up to a whole pixel and clamp to the source
  assign rounded = {1'b0, prod_q} + HALF;
  assign whole   = rounded[PROD_W:ROUND_SH];
  assign coord_d = (whole > (PROD_W-ROUND_SH+1)'(axis_i.lim)) ? axis_i.lim
                                                               : whole[COORD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

/* design/staggered_grid_sample_coords.sv */
// top level: staggered grid sample coordinate generator
// the result is registered through the phase stage, the product stage and the round and clamp stage, in that order
// throughput: one item per cycle, each stage passes its item on when the next is free
// each stage holds its item while the one after it is full, so a waiting result
// stops the input only once all three stages hold an item
// reset: registers return to their defaults, all stages empty
module staggered_grid_sample_coords import sgsc_pkg::*; #(
  parameter int unsigned OUT_ROWS = OUT_ROWS_DEF,
  parameter int unsigned OUT_COLS = OUT_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sgsc_in_if.sink               in_i,
  sgsc_out_if.source            out_o
);

  cfg_t              cfg;
  axis_cfg_t         row_axis;
  axis_cfg_t         col_axis;
  stage_ctrl_t       ctrl;
  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  logic [QUART_W-1:0] rq, cq;
  logic [FACT_W-1:0] row_fact_d, col_fact_d;
  logic [FACT_W-1:0] row_fact_q, col_fact_q;

  sgsc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sgsc_gap_calc #(.OUT_SIZE(OUT_ROWS)) u_row_gap (
    .clk_i          (clk_i),
    .use_auto_gap_i (cfg.use_auto_gap),
    .reg_gap_i      (cfg.row_gap),
    .size_i         (cfg.source_rows),
    .axis_o         (row_axis)
  );

  sgsc_gap_calc #(.OUT_SIZE(OUT_COLS)) u_col_gap (
    .clk_i          (clk_i),
    .use_auto_gap_i (cfg.use_auto_gap),
    .reg_gap_i      (cfg.column_gap),
    .size_i         (cfg.source_cols),
    .axis_o         (col_axis)
  );

  // stage handshake, a stage takes an item when empty or draining
  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready   = rdy1;
  assign ctrl.prod_en = rdy2 && v1_q;
  assign ctrl.out_en  = rdy3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // phase selection, mirrored on odd rows or columns
  always_comb begin
    if (cfg.stagger_mode == MODE_H_HALF) begin
      cq = Q_HALF;
    end else if (cfg.stagger_mode == MODE_H_QUARTER) begin
      cq = Q_ONE;
    end else begin
      cq = Q_THREE;
    end
    rq = (cfg.stagger_mode == MODE_V_QUARTER) ? Q_ONE : Q_THREE;
    if (cfg.stagger_mode <= MODE_H_3QUART) begin
      if (in_i.out_row[0]) begin
        cq = Q_FULL - cq;
      end
      rq = Q_HALF;
    end else begin
      if (in_i.out_col[0]) begin
        rq = Q_FULL - rq;
      end
      cq = Q_HALF;
    end
  end

  // position factor 4 * index + quarters
  assign row_fact_d = {1'b0, in_i.out_row, 2'b00} + FACT_W'(rq);
  assign col_fact_d = {1'b0, in_i.out_col, 2'b00} + FACT_W'(cq);

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      row_fact_q <= row_fact_d;
      col_fact_q <= col_fact_d;
    end
  end

  sgsc_place u_row_place (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .factor_i (row_fact_q),
    .axis_i   (row_axis),
    .coord_o  (out_o.sample_row)
  );

  sgsc_place u_col_place (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .factor_i (col_fact_q),
    .axis_i   (col_axis),
    .coord_o  (out_o.sample_col)
  );

  assign out_o.valid = v3_q;

  // an accepted item always lands in the first stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted item lost at first stage");

  // an item moved on from the first stage lands in the product stage
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.prod_en |=> v2_q)
    else $error("item lost between first and product stage");

  // with no result waiting the pipeline never refuses an item
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |-> in_i.ready)
    else $error("input stalled with empty output stage");

  // a stalled result stage keeps its item
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_o.ready |=> v3_q && !ctrl.out_en || v3_q)
    else $error("stalled result dropped");

endmodule
